[sv/idct8_pkg.sv]
package idct8_pkg;

  localparam int DATA_W = 16;
  localparam int OUT_W  = DATA_W + 2;
  localparam int SUM_W  = DATA_W + 1;
  localparam int K_W    = 16;
  localparam int FRAC_W = 15;
  localparam int PROD_W = SUM_W + K_W;
  localparam int RND_W  = PROD_W - FRAC_W;
  localparam int ACC_W  = OUT_W + 2;
  localparam int NUM_PTS = 8;
  localparam int NUM_ODD = 4;

  typedef logic signed [DATA_W-1:0] coef_t;
  typedef logic signed [OUT_W-1:0]  samp_t;
  typedef logic signed [SUM_W-1:0]  sum_t;
  typedef logic signed [K_W-1:0]    kconst_t;
  typedef logic signed [PROD_W-1:0] prod_t;
  typedef logic signed [RND_W-1:0]  rnd_t;
  typedef logic signed [ACC_W-1:0]  acc_t;

  // basis constants, q1.15, 0.5*cos(angle)
  localparam kconst_t K_A = 16'sd11585;
  localparam kconst_t K_B = 16'sd16069;
  localparam kconst_t K_C = 16'sd15137;
  localparam kconst_t K_D = 16'sd13623;
  localparam kconst_t K_E = 16'sd9102;
  localparam kconst_t K_F = 16'sd6270;
  localparam kconst_t K_G = 16'sd3196;

  localparam prod_t RND_HALF = prod_t'(1) <<< (FRAC_W - 1);

  // odd part: row r gives od[r], column c multiplies x1, x3, x5, x7
  localparam kconst_t ODD_K [NUM_ODD][NUM_ODD] = '{
    '{K_B, K_D, K_E, K_G},
    '{K_D, K_G, K_B, K_E},
    '{K_E, K_B, K_G, K_D},
    '{K_G, K_E, K_D, K_B}
  };
  // bit c set: that term is subtracted
  localparam logic [NUM_ODD-1:0] ODD_NEG [NUM_ODD] = '{
    4'b0000, 4'b1110, 4'b0010, 4'b1010
  };

  localparam acc_t ACC_HI = acc_t'((2 ** (OUT_W - 1)) - 1);
  localparam acc_t ACC_LO = acc_t'(-(2 ** (OUT_W - 1)));

  typedef struct {
    sum_t ev_s;
    sum_t ev_d;
    sum_t x2;
    sum_t x6;
    sum_t xo [NUM_ODD];
  } pre_t;

  typedef struct {
    rnd_t ta0;
    rnd_t ta1;
    rnd_t tc2;
    rnd_t tf6;
    rnd_t tf2;
    rnd_t tc6;
    rnd_t po [NUM_ODD][NUM_ODD];
  } prd_t;

  typedef struct {
    acc_t ev [NUM_ODD];
    acc_t od [NUM_ODD];
  } part_t;

  // product rounded to nearest, ties toward plus infinity
  function automatic rnd_t rmul(input sum_t x, input kconst_t k);
    prod_t p;
    p = prod_t'(x) * prod_t'(k);
    p = p + RND_HALF;
    return rnd_t'(p[PROD_W-1:FRAC_W]);
  endfunction

  function automatic samp_t sat(input acc_t v);
    acc_t r;
    r = v;
    if (v > ACC_HI) r = ACC_HI;
    if (v < ACC_LO) r = ACC_LO;
    return samp_t'(r[OUT_W-1:0]);
  endfunction

endpackage

[sv/idct8_coef_if.sv]
interface idct8_coef_if;
  logic valid;
  logic ready;
  idct8_pkg::coef_t coef_0;
  idct8_pkg::coef_t coef_1;
  idct8_pkg::coef_t coef_2;
  idct8_pkg::coef_t coef_3;
  idct8_pkg::coef_t coef_4;
  idct8_pkg::coef_t coef_5;
  idct8_pkg::coef_t coef_6;
  idct8_pkg::coef_t coef_7;

  modport source (
    output valid, coef_0, coef_1, coef_2, coef_3, coef_4, coef_5, coef_6, coef_7,
    input  ready
  );
  modport sink (
    input  valid, coef_0, coef_1, coef_2, coef_3, coef_4, coef_5, coef_6, coef_7,
    output ready
  );
endinterface

[sv/idct8_samp_if.sv]
interface idct8_samp_if;
  logic valid;
  logic ready;
  idct8_pkg::samp_t out_0;
  idct8_pkg::samp_t out_1;
  idct8_pkg::samp_t out_2;
  idct8_pkg::samp_t out_3;
  idct8_pkg::samp_t out_4;
  idct8_pkg::samp_t out_5;
  idct8_pkg::samp_t out_6;
  idct8_pkg::samp_t out_7;

  modport source (
    output valid, out_0, out_1, out_2, out_3, out_4, out_5, out_6, out_7,
    input  ready
  );
  modport sink (
    input  valid, out_0, out_1, out_2, out_3, out_4, out_5, out_6, out_7,
    output ready
  );
endinterface

[sv/idct8_8point_1d_core.sv]
// channel      | dir | handshake    | word
// coef_chan_i  | in  | valid/ready  | coef_0..coef_7, 16-bit signed
// samp_chan_o  | out | valid/ready  | out_0..out_7, 18-bit signed, saturated
//
// one word per cycle sustained while the output is not stalled
// stages: pre-add, constant multiply with rounding, even/odd sums, butterfly
// each stage holds a valid bit and takes a new word when empty or draining,
// so bubbles collapse and a stall at the output backs up stage by stage
// reset clears the valid bits only; no memory, no clearing pass
module idct_8point_1d_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  idct8_coef_if.sink         coef_chan_i,
  idct8_samp_if.source       samp_chan_o
);

  idct8_pkg::coef_t coef [idct8_pkg::NUM_PTS];
  idct8_pkg::samp_t samp [idct8_pkg::NUM_PTS];

  logic             pre_valid, pre_ready;
  logic             mul_valid, mul_ready;
  logic             sum_valid, sum_ready;
  idct8_pkg::pre_t  pre_data;
  idct8_pkg::prd_t  mul_data;
  idct8_pkg::part_t sum_data;

  assign coef[0] = coef_chan_i.coef_0;
  assign coef[1] = coef_chan_i.coef_1;
  assign coef[2] = coef_chan_i.coef_2;
  assign coef[3] = coef_chan_i.coef_3;
  assign coef[4] = coef_chan_i.coef_4;
  assign coef[5] = coef_chan_i.coef_5;
  assign coef[6] = coef_chan_i.coef_6;
  assign coef[7] = coef_chan_i.coef_7;

  idct8_pre u_pre (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (coef_chan_i.valid),
    .ready_o (coef_chan_i.ready),
    .coef_i  (coef),
    .valid_o (pre_valid),
    .ready_i (pre_ready),
    .data_o  (pre_data)
  );

  idct8_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (pre_valid),
    .ready_o (pre_ready),
    .data_i  (pre_data),
    .valid_o (mul_valid),
    .ready_i (mul_ready),
    .data_o  (mul_data)
  );

  idct8_sum u_sum (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (mul_valid),
    .ready_o (mul_ready),
    .data_i  (mul_data),
    .valid_o (sum_valid),
    .ready_i (sum_ready),
    .data_o  (sum_data)
  );

  idct8_bfly u_bfly (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (sum_valid),
    .ready_o (sum_ready),
    .data_i  (sum_data),
    .valid_o (samp_chan_o.valid),
    .ready_i (samp_chan_o.ready),
    .samp_o  (samp)
  );

  assign samp_chan_o.out_0 = samp[0];
  assign samp_chan_o.out_1 = samp[1];
  assign samp_chan_o.out_2 = samp[2];
  assign samp_chan_o.out_3 = samp[3];
  assign samp_chan_o.out_4 = samp[4];
  assign samp_chan_o.out_5 = samp[5];
  assign samp_chan_o.out_6 = samp[6];
  assign samp_chan_o.out_7 = samp[7];

`ifndef SYNTH
  // empty output stage means every stage upstream can take a word
  a_ready_when_out_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !samp_chan_o.valid |-> coef_chan_i.ready)
    else $error("input stalled with empty output stage");

  // with the output draining, a word that entered shows up at the output after pre-add, multiply, sum and butterfly
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (coef_chan_i.valid && coef_chan_i.ready
     ##1 samp_chan_o.ready ##1 samp_chan_o.ready ##1 samp_chan_o.ready)
    |=> samp_chan_o.valid)
    else $error("word lost or late in pipeline");

  // all-zero coefficients give all-zero samples, checked on out_0 and out_7
  a_zero_in_zero_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (coef_chan_i.valid && coef_chan_i.ready &&
     coef_chan_i.coef_0 == '0 && coef_chan_i.coef_1 == '0 &&
     coef_chan_i.coef_2 == '0 && coef_chan_i.coef_3 == '0 &&
     coef_chan_i.coef_4 == '0 && coef_chan_i.coef_5 == '0 &&
     coef_chan_i.coef_6 == '0 && coef_chan_i.coef_7 == '0
     ##1 samp_chan_o.ready ##1 samp_chan_o.ready ##1 samp_chan_o.ready)
    |=> (samp_chan_o.out_0 == '0 && samp_chan_o.out_7 == '0))
    else $error("nonzero output for zero input");
`endif

endmodule

[sv/idct8_pre.sv]
module idct8_pre (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  output logic               ready_o,
  input  idct8_pkg::coef_t   coef_i [idct8_pkg::NUM_PTS],
  output logic               valid_o,
  input  logic               ready_i,
  output idct8_pkg::pre_t    data_o
);

  logic            valid_q;
  idct8_pkg::pre_t data_d;
  idct8_pkg::pre_t data_q;

  assign ready_o = !valid_q || ready_i;

  always_comb begin
    data_d.ev_s = idct8_pkg::SUM_W'(coef_i[0]) + idct8_pkg::SUM_W'(coef_i[4]);
    data_d.ev_d = idct8_pkg::SUM_W'(coef_i[0]) - idct8_pkg::SUM_W'(coef_i[4]);
    data_d.x2   = idct8_pkg::SUM_W'(coef_i[2]);
    data_d.x6   = idct8_pkg::SUM_W'(coef_i[6]);
    for (int c = 0; c < idct8_pkg::NUM_ODD; c++) begin
      data_d.xo[c] = idct8_pkg::SUM_W'(coef_i[2*c+1]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

[sv/idct8_mul.sv]
module idct8_mul (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  output logic               ready_o,
  input  idct8_pkg::pre_t    data_i,
  output logic               valid_o,
  input  logic               ready_i,
  output idct8_pkg::prd_t    data_o
);

  logic            valid_q;
  idct8_pkg::prd_t data_d;
  idct8_pkg::prd_t data_q;

  assign ready_o = !valid_q || ready_i;

  always_comb begin
    data_d.ta0 = idct8_pkg::rmul(data_i.ev_s, idct8_pkg::K_A);
    data_d.ta1 = idct8_pkg::rmul(data_i.ev_d, idct8_pkg::K_A);
    data_d.tc2 = idct8_pkg::rmul(data_i.x2, idct8_pkg::K_C);
    data_d.tf6 = idct8_pkg::rmul(data_i.x6, idct8_pkg::K_F);
    data_d.tf2 = idct8_pkg::rmul(data_i.x2, idct8_pkg::K_F);
    data_d.tc6 = idct8_pkg::rmul(data_i.x6, idct8_pkg::K_C);
    for (int r = 0; r < idct8_pkg::NUM_ODD; r++) begin
      for (int c = 0; c < idct8_pkg::NUM_ODD; c++) begin
        data_d.po[r][c] = idct8_pkg::rmul(data_i.xo[c], idct8_pkg::ODD_K[r][c]);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

[sv/idct8_sum.sv]
module idct8_sum (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  output logic               ready_o,
  input  idct8_pkg::prd_t    data_i,
  output logic               valid_o,
  input  logic               ready_i,
  output idct8_pkg::part_t   data_o
);

  logic             valid_q;
  idct8_pkg::part_t data_d;
  idct8_pkg::part_t data_q;

  assign ready_o = !valid_q || ready_i;

  always_comb begin
    idct8_pkg::acc_t t0, t1, t2, t3, acc;
    t0 = idct8_pkg::ACC_W'(data_i.ta0);
    t3 = idct8_pkg::ACC_W'(data_i.ta1);
    t1 = idct8_pkg::ACC_W'(data_i.tc2) + idct8_pkg::ACC_W'(data_i.tf6);
    t2 = idct8_pkg::ACC_W'(data_i.tf2) - idct8_pkg::ACC_W'(data_i.tc6);
    data_d.ev[0] = t0 + t1;
    data_d.ev[1] = t3 + t2;
    data_d.ev[2] = t3 - t2;
    data_d.ev[3] = t0 - t1;
    for (int r = 0; r < idct8_pkg::NUM_ODD; r++) begin
      acc = '0;
      for (int c = 0; c < idct8_pkg::NUM_ODD; c++) begin
        if (idct8_pkg::ODD_NEG[r][c]) begin
          acc = acc - idct8_pkg::ACC_W'(data_i.po[r][c]);
        end else begin
          acc = acc + idct8_pkg::ACC_W'(data_i.po[r][c]);
        end
      end
      data_d.od[r] = acc;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

[sv/idct8_bfly.sv]
module idct8_bfly (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  output logic               ready_o,
  input  idct8_pkg::part_t   data_i,
  output logic               valid_o,
  input  logic               ready_i,
  output idct8_pkg::samp_t   samp_o [idct8_pkg::NUM_PTS]
);

  logic             valid_q;
  idct8_pkg::samp_t samp_d [idct8_pkg::NUM_PTS];
  idct8_pkg::samp_t samp_q [idct8_pkg::NUM_PTS];

  assign ready_o = !valid_q || ready_i;

  always_comb begin
    for (int k = 0; k < idct8_pkg::NUM_ODD; k++) begin
      samp_d[k] = idct8_pkg::sat(data_i.ev[k] + data_i.od[k]);
      samp_d[idct8_pkg::NUM_PTS-1-k] = idct8_pkg::sat(data_i.ev[k] - data_i.od[k]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      samp_q <= samp_d;
    end
  end

  assign valid_o = valid_q;
  assign samp_o  = samp_q;

endmodule
